// ----- rtl/core/vtct_pkg.sv -----
`default_nettype none

package vtct_pkg;

    localparam logic [1:0] FUNC_SCHED  = 2'd0;
    localparam logic [1:0] FUNC_CANCEL = 2'd1;
    localparam logic [1:0] FUNC_ADV_BY = 2'd2;
    localparam logic [1:0] FUNC_ADV_TO = 2'd3;

    localparam logic [2:0] KIND_ISSUED = 3'd0;
    localparam logic [2:0] KIND_FULL   = 3'd1;
    localparam logic [2:0] KIND_CANCEL = 3'd2;
    localparam logic [2:0] KIND_FIRED  = 3'd3;
    localparam logic [2:0] KIND_DONE   = 3'd4;

    localparam logic [31:0] FIRST_ID = 32'd1;
    localparam logic [31:0] LAST_ID  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] time_value;
        logic [31:0] handle_in;
        logic [31:0] callback_tag;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] handle_out;
        logic [31:0] tag_out;
        logic        ok;
        logic [63:0] now_ticks;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [31:0] id;
        logic [63:0] expiry;
        logic [31:0] tag;
    } entry_t;

    typedef struct packed {
        logic latch;
        logic sched;
        logic scan_start;
        logic clk_add;
        logic clk_set;
        logic rd_issue;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       fwd;
        logic       empty;
        logic       ev_emit;
        logic       out_free;
        logic       scan_last;
    } stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/vtct_ram.sv -----
`default_nettype none

module vtct_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/vtct_ctrl.sv -----
`default_nettype none

module vtct_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire vtct_pkg::stat_t stat,
    output vtct_pkg::cmd_t     cmd
);

    import vtct_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_SCHED = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_EV    = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (stat.func)
                    FUNC_SCHED:
                    begin
                        state_next = S_SCHED;
                    end
                    FUNC_CANCEL:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = stat.empty ? S_FIN : S_RD;
                    end
                    FUNC_ADV_BY:
                    begin
                        cmd.clk_add    = 1'b1;
                        cmd.scan_start = 1'b1;
                        state_next     = stat.empty ? S_FIN : S_RD;
                    end
                    default:
                    begin
                        if (stat.fwd)
                        begin
                            cmd.clk_set    = 1'b1;
                            cmd.scan_start = 1'b1;
                            state_next     = stat.empty ? S_FIN : S_RD;
                        end
                        else
                        begin
                            state_next = S_FIN;
                        end
                    end
                endcase
            end
            S_SCHED:
            begin
                if (stat.out_free)
                begin
                    cmd.sched  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_EV;
            end
            S_EV:
            begin
                if (!stat.ev_emit || stat.out_free)
                begin
                    cmd.step   = 1'b1;
                    state_next = stat.scan_last ? S_FIN : S_RD;
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/vtct_dpath.sv -----
`default_nettype none

module vtct_dpath #(
    parameter int TIMER_SLOTS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire vtct_pkg::in_item_t  in_data,
    input  wire vtct_pkg::cmd_t      cmd,
    output vtct_pkg::stat_t          stat,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output vtct_pkg::out_item_t      out_data
);

    import vtct_pkg::*;

    localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TIMER_SLOTS);

    logic [1:0]  func_reg;
    logic [63:0] tv_reg;
    logic [31:0] hin_reg;
    logic [31:0] tag_reg;

    logic [63:0]   clock_reg, clock_next;
    logic [31:0]   next_id_reg, next_id_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] rd_reg, rd_next;
    logic [CW-1:0] wr_reg, wr_next;
    logic          matched_reg, matched_next;
    logic          scan_reg, scan_next;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_data_reg, out_data_next;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    entry_t        ram_wdata;
    entry_t        entry;
    logic [$bits(entry_t)-1:0] ram_rdata;

    logic is_adv;
    logic full;
    logic drop;
    logic out_free;
    logic load_out;

    vtct_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TIMER_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_issue),
        .raddr (rd_reg),
        .rdata (ram_rdata)
    );

    assign entry    = entry_t'(ram_rdata);
    assign is_adv   = func_reg[1];
    assign full     = (count_reg == FULL_COUNT);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        if (is_adv)
        begin
            drop = (clock_reg >= entry.expiry);
        end
        else
        begin
            drop = !matched_reg && (hin_reg != 32'd0) && (entry.id == hin_reg);
        end
    end

    assign stat.func      = func_reg;
    assign stat.fwd       = (tv_reg > clock_reg);
    assign stat.empty     = (count_reg == '0);
    assign stat.ev_emit   = drop && is_adv;
    assign stat.out_free  = out_free;
    assign stat.scan_last = ((CW'(rd_reg) + CW'(1)) == count_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            func_reg <= in_data.func;
            tv_reg   <= in_data.time_value;
            hin_reg  <= in_data.handle_in;
            tag_reg  <= in_data.callback_tag;
        end
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        clock_next    = clock_reg;
        next_id_next  = next_id_reg;
        count_next    = count_reg;
        rd_next       = rd_reg;
        wr_next       = wr_reg;
        matched_next  = matched_reg;
        scan_next     = scan_reg;
        ram_we        = 1'b0;
        ram_waddr     = count_reg[IW-1:0];
        ram_wdata     = '{id: next_id_reg, expiry: tv_reg, tag: tag_reg};
        load_out      = 1'b0;
        out_data_next = out_data_reg;

        if (cmd.clk_add)
        begin
            clock_next = clock_reg + tv_reg;
        end
        if (cmd.clk_set)
        begin
            clock_next = tv_reg;
        end
        if (cmd.scan_start)
        begin
            rd_next      = '0;
            wr_next      = '0;
            matched_next = 1'b0;
            scan_next    = 1'b1;
        end

        if (cmd.sched)
        begin
            load_out = 1'b1;
            if (full)
            begin
                out_data_next = '{kind: KIND_FULL, handle_out: 32'd0, tag_out: 32'd0,
                                  ok: 1'b0, now_ticks: clock_reg, last: 1'b1};
            end
            else
            begin
                ram_we       = 1'b1;
                count_next   = count_reg + CW'(1);
                next_id_next = (next_id_reg == LAST_ID) ? FIRST_ID : next_id_reg + 32'd1;
                out_data_next = '{kind: KIND_ISSUED, handle_out: next_id_reg, tag_out: 32'd0,
                                  ok: 1'b1, now_ticks: clock_reg, last: 1'b1};
            end
        end

        if (cmd.step)
        begin
            rd_next = rd_reg + IW'(1);
            if (!drop)
            begin
                ram_we    = 1'b1;
                ram_waddr = wr_reg[IW-1:0];
                ram_wdata = entry;
                wr_next   = wr_reg + CW'(1);
            end
            else if (is_adv)
            begin
                load_out      = 1'b1;
                out_data_next = '{kind: KIND_FIRED, handle_out: entry.id, tag_out: entry.tag,
                                  ok: 1'b1, now_ticks: clock_reg, last: 1'b0};
            end
            else
            begin
                matched_next = 1'b1;
            end
        end

        if (cmd.finish)
        begin
            load_out = 1'b1;
            if (scan_reg)
            begin
                count_next = wr_reg;
                scan_next  = 1'b0;
            end
            if (is_adv)
            begin
                out_data_next = '{kind: KIND_DONE, handle_out: 32'd0, tag_out: 32'd0,
                                  ok: 1'b1, now_ticks: clock_reg, last: 1'b1};
            end
            else
            begin
                out_data_next = '{kind: KIND_CANCEL, handle_out: 32'd0, tag_out: 32'd0,
                                  ok: matched_reg, now_ticks: clock_reg, last: 1'b1};
            end
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg     <= '0;
            next_id_reg   <= FIRST_ID;
            count_reg     <= '0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            matched_reg   <= 1'b0;
            scan_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clock_reg     <= clock_next;
            next_id_reg   <= next_id_next;
            count_reg     <= count_next;
            rd_reg        <= rd_next;
            wr_reg        <= wr_next;
            matched_reg   <= matched_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_COUNT)
        else $error("live timer count above table size");

    assert property (@(posedge clk) disable iff (!rst_n) next_id_reg != 32'd0)
        else $error("handle id zero pending issue");

    assert property (@(posedge clk) disable iff (!rst_n) load_out |-> out_free)
        else $error("result register overwritten before transfer");

    assert property (@(posedge clk) disable iff (!rst_n) !(cmd.sched && cmd.step))
        else $error("schedule write during scan");

    assert property (@(posedge clk) disable iff (!rst_n) scan_reg |-> wr_reg <= count_reg)
        else $error("compaction pointer past live count");

endmodule

`default_nettype wire

// ----- rtl/core/virtual_timer_callback_table.sv -----
`default_nettype none

// One-shot timer table over a 64-bit virtual tick clock, with up to TIMER_SLOTS live
// timers kept in issue order in a slot RAM. A schedule goes from accept through the
// dispatch and schedule states to its result. A cancel, or an advance that moves the
// clock, scans every live timer; an advance-to that leaves the clock skips the scan.
// Any step that loads a result waits while the output register is still occupied.
// The scan walks the slot RAM in sequence, a read step and then an evaluate-and-compact
// step per live entry over its single read port. A result is held in an output
// register, so the next command is accepted once the previous one has left its last
// result there.
module virtual_timer_callback_table #(
    parameter int TIMER_SLOTS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire vtct_pkg::in_item_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output vtct_pkg::out_item_t     out_data
);

    import vtct_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    vtct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vtct_dpath #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
